### rtl/core/pva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int VOICE_SLOTS = 16;
    localparam int VOICE_W    = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(VOICE_SLOTS + 1);

    localparam int CMD_W      = 2;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int VID_W      = 4;
    localparam int ASSIGN_W   = 4;
    localparam int MASK_W     = 16;
    localparam int POL_W      = 2;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int BIRTH_W    = 32;
    localparam int SCORE_W    = 34;

    localparam logic [CFG_IDX_W-1:0] REG_STEAL_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_COUNT  = 1'b1;

    localparam logic [POL_W-1:0] POL_RESET = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_NOTE_ON    = 2'd0,
        CMD_NOTE_OFF   = 2'd1,
        CMD_VOICE_DONE = 2'd2
    } cmd_t;

    typedef enum logic [POL_W-1:0] {
        POL_HIGHEST = 2'd0,
        POL_LOWEST  = 2'd1,
        POL_NEWEST  = 2'd2,
        POL_OLDEST  = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic                      valid;
        logic                      done;
        logic                      idle;
        logic                      have_best;
        logic signed [SCORE_W-1:0] best_score;
        logic [VOICE_W-1:0]        best_idx;
        logic [CNT_W-1:0]          remaining;
    } token_t;

    // updates broadcast from the controller to every cell
    typedef struct packed {
        logic               clear;
        logic               note_on;
        logic               note_off;
        logic               vdone;
        logic [VOICE_W-1:0] idx;
        logic [NOTE_W-1:0]  note;
        logic [POL_W-1:0]   policy;
        logic [BIRTH_W-1:0] counter;
    } bcast_t;

endpackage

### rtl/core/pva_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_cell
// One voice slot: holds the voice state, scores it against the passing
// search token and hands the token on to the next slot.
// ----------------------------------------------------------------------------
module pva_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pva_pkg::VOICE_W-1:0]  my_idx,
    input  logic                         active,
    input  pva_pkg::token_t              tok_in,
    input  pva_pkg::bcast_t              bc,
    output pva_pkg::token_t              tok_out,
    output logic                         rel_hit
);

    logic                               sounding_reg;
    logic                               sounding_next;
    logic                               held_reg;
    logic                               held_next;
    logic [pva_pkg::NOTE_W-1:0]         note_reg;
    logic [pva_pkg::NOTE_W-1:0]         note_next;
    logic [pva_pkg::BIRTH_W-1:0]        birth_reg;
    pva_pkg::token_t                    tok_reg;
    pva_pkg::token_t                    tok_next;

    logic [pva_pkg::BIRTH_W-1:0]        age;
    logic signed [pva_pkg::SCORE_W-1:0] base;
    logic signed [pva_pkg::SCORE_W-1:0] score;
    logic                               hit_idx;

    assign hit_idx = (bc.idx == my_idx);
    assign rel_hit = active && sounding_reg && held_reg && (note_reg == bc.note);
    assign tok_out = tok_reg;

    // steal score of this voice
    always_comb
    begin
        age = bc.counter - birth_reg;
        case (bc.policy)
            pva_pkg::POL_HIGHEST: base = -$signed(pva_pkg::SCORE_W'(note_reg));
            pva_pkg::POL_LOWEST:  base = $signed(pva_pkg::SCORE_W'(note_reg));
            pva_pkg::POL_NEWEST:  base = -$signed(pva_pkg::SCORE_W'(age));
            default:              base = $signed(pva_pkg::SCORE_W'(age));
        endcase
        score = base + $signed(pva_pkg::SCORE_W'(!held_reg));
    end

    // token processing
    always_comb
    begin
        tok_next = '0;
        if (active && tok_in.valid && !tok_in.done)
        begin
            tok_next = tok_in;
            if (!sounding_reg)
            begin
                tok_next.done     = 1'b1;
                tok_next.idle     = 1'b1;
                tok_next.best_idx = my_idx;
            end
            else
            begin
                if (!tok_in.have_best || (score > tok_in.best_score))
                begin
                    tok_next.have_best  = 1'b1;
                    tok_next.best_score = score;
                    tok_next.best_idx   = my_idx;
                end
                tok_next.remaining = tok_in.remaining - pva_pkg::CNT_W'(1);
                tok_next.done      = (tok_in.remaining == pva_pkg::CNT_W'(1));
            end
        end
    end

    // voice state updates
    always_comb
    begin
        sounding_next = sounding_reg;
        held_next     = held_reg;
        note_next     = note_reg;
        if (bc.clear)
        begin
            sounding_next = 1'b0;
            held_next     = 1'b0;
            note_next     = '0;
        end
        else if (bc.note_on && hit_idx)
        begin
            sounding_next = 1'b1;
            held_next     = 1'b1;
            note_next     = bc.note;
        end
        else if (bc.note_off && rel_hit)
        begin
            held_next = 1'b0;
        end
        else if (bc.vdone && hit_idx)
        begin
            sounding_next = 1'b0;
            held_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sounding_reg <= 1'b0;
            held_reg     <= 1'b0;
            note_reg     <= '0;
            tok_reg      <= '0;
        end
        else
        begin
            sounding_reg <= sounding_next;
            held_reg     <= held_next;
            note_reg     <= note_next;
            tok_reg      <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bc.note_on && hit_idx)
        begin
            birth_reg <= bc.counter;
        end
    end

endmodule

### rtl/core/pva_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_ctrl
// Command sequencer: takes input beats, launches the voice search, commits
// the chosen update to the cells and holds the result beat.
// ----------------------------------------------------------------------------
module pva_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pva_pkg::CMD_W-1:0]       command,
    input  logic [pva_pkg::NOTE_W-1:0]      note,
    input  logic [pva_pkg::VEL_W-1:0]       velocity,
    input  logic [pva_pkg::VID_W-1:0]       voice_id,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pva_pkg::ASSIGN_W-1:0]    assigned_voice,
    output logic                            stole_voice,
    output logic                            start_valid,
    output logic [pva_pkg::NOTE_W-1:0]      out_note,
    output logic [pva_pkg::VEL_W-1:0]       out_velocity,
    output logic [pva_pkg::MASK_W-1:0]      released_mask,
    input  logic                            cfg_we,
    input  logic [pva_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pva_pkg::CFG_W-1:0]       cfg_data,
    input  pva_pkg::token_t                 scan_res,
    input  logic [pva_pkg::VOICE_SLOTS-1:0] rel_mask,
    output pva_pkg::bcast_t                 bc,
    output logic                            launch,
    output pva_pkg::token_t                 launch_tok,
    output logic [pva_pkg::VOICE_W-1:0]     start_idx,
    output logic [pva_pkg::CNT_W-1:0]       count
);

    pva_pkg::state_t                 state_reg;
    pva_pkg::state_t                 state_next;

    logic [pva_pkg::POL_W-1:0]       policy_reg;
    logic [pva_pkg::CNT_W-1:0]       count_reg;
    logic [pva_pkg::CNT_W-1:0]       count_next;
    logic [pva_pkg::BIRTH_W-1:0]     counter_reg;
    logic [pva_pkg::VOICE_W-1:0]     start_reg;

    logic [pva_pkg::CMD_W-1:0]       cmd_reg;
    logic [pva_pkg::NOTE_W-1:0]      note_reg;
    logic [pva_pkg::VEL_W-1:0]       vel_reg;
    logic [pva_pkg::VID_W-1:0]       vid_reg;
    logic [pva_pkg::VOICE_W-1:0]     chosen_reg;
    logic                            stole_reg;

    logic                            out_valid_reg;
    logic [pva_pkg::ASSIGN_W-1:0]    assigned_reg;
    logic                            stole_out_reg;
    logic                            start_reg_out;
    logic [pva_pkg::NOTE_W-1:0]      out_note_reg;
    logic [pva_pkg::VEL_W-1:0]       out_vel_reg;
    logic [pva_pkg::MASK_W-1:0]      mask_reg;

    logic                            accept;
    logic                            out_free;
    logic                            commit;
    logic                            is_on;
    logic                            is_off;
    logic                            vid_ok;
    logic                            cfg_count_wr;

    assign accept       = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign is_on        = (cmd_reg == pva_pkg::CMD_NOTE_ON);
    assign is_off       = (cmd_reg == pva_pkg::CMD_NOTE_OFF);
    assign vid_ok       = (cmd_reg == pva_pkg::CMD_VOICE_DONE)
                          && (int'(vid_reg) < int'(count_reg));
    assign cfg_count_wr = cfg_we && (cfg_index == pva_pkg::REG_VOICE_COUNT);

    assign start_idx = (int'(start_reg) >= int'(count_reg)) ? '0 : start_reg;
    assign count     = count_reg;

    assign out_valid      = out_valid_reg;
    assign assigned_voice = assigned_reg;
    assign stole_voice    = stole_out_reg;
    assign start_valid    = start_reg_out;
    assign out_note       = out_note_reg;
    assign out_velocity   = out_vel_reg;
    assign released_mask  = mask_reg;

    // clamp of a written voice count
    always_comb
    begin
        if (cfg_data == '0)
        begin
            count_next = pva_pkg::CNT_W'(1);
        end
        else if (int'(cfg_data) > pva_pkg::VOICE_SLOTS)
        begin
            count_next = pva_pkg::CNT_W'(pva_pkg::VOICE_SLOTS);
        end
        else
        begin
            count_next = pva_pkg::CNT_W'(cfg_data);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (command == pva_pkg::CMD_NOTE_ON) ?
                                 pva_pkg::ST_SCAN : pva_pkg::ST_COMMIT;
                end
            end
            pva_pkg::ST_SCAN:
            begin
                if (scan_res.valid)
                begin
                    state_next = pva_pkg::ST_COMMIT;
                end
            end
            pva_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = pva_pkg::ST_IDLE;
                end
            end
            default: state_next = pva_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            pva_pkg::ST_IDLE:   in_ready = 1'b1;
            pva_pkg::ST_SCAN:   in_ready = 1'b0;
            pva_pkg::ST_COMMIT: commit   = out_free;
            default:            in_ready = 1'b0;
        endcase
    end

    assign launch = accept && (command == pva_pkg::CMD_NOTE_ON);

    always_comb
    begin
        launch_tok           = '0;
        launch_tok.valid     = 1'b1;
        launch_tok.remaining = count_reg;
    end

    always_comb
    begin
        bc          = '0;
        bc.clear    = cfg_count_wr;
        bc.note_on  = commit && is_on;
        bc.note_off = commit && is_off;
        bc.vdone    = commit && vid_ok;
        bc.idx      = is_on ? chosen_reg : pva_pkg::VOICE_W'(vid_reg);
        bc.note     = note_reg;
        bc.policy   = policy_reg;
        bc.counter  = counter_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pva_pkg::ST_IDLE;
            policy_reg    <= pva_pkg::POL_RESET;
            count_reg     <= pva_pkg::CNT_W'(pva_pkg::VOICE_SLOTS);
            counter_reg   <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && (cfg_index == pva_pkg::REG_STEAL_POLICY))
            begin
                policy_reg <= cfg_data[pva_pkg::POL_W-1:0];
            end
            if (cfg_count_wr)
            begin
                count_reg   <= count_next;
                counter_reg <= '0;
                start_reg   <= '0;
            end
            else if (commit && is_on)
            begin
                counter_reg <= counter_reg + pva_pkg::BIRTH_W'(1);
                start_reg   <= chosen_reg;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            note_reg <= note;
            vel_reg  <= velocity;
            vid_reg  <= voice_id;
        end
        if ((state_reg == pva_pkg::ST_SCAN) && scan_res.valid)
        begin
            chosen_reg <= scan_res.best_idx;
            stole_reg  <= !scan_res.idle;
        end
        if (commit)
        begin
            assigned_reg  <= is_on ? pva_pkg::ASSIGN_W'(chosen_reg) : '0;
            stole_out_reg <= is_on && stole_reg;
            start_reg_out <= is_on;
            out_note_reg  <= is_on ? note_reg : '0;
            out_vel_reg   <= is_on ? vel_reg : '0;
            mask_reg      <= is_off ? pva_pkg::MASK_W'(rel_mask) : '0;
        end
    end

    a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.valid |-> state_reg == pva_pkg::ST_SCAN)
        else $error("search result outside scan");

    a_commit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("commit did not load result beat");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (int'(count_reg) <= pva_pkg::VOICE_SLOTS))
        else $error("voice count out of range");

endmodule

### rtl/core/polyphonic_voice_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_top
// Voice allocator with stealing: a ring of voice cells passes a search token.
// Note on: the search visits cells up to and including the first idle
//   voice, or all voice_count cells when one is stolen; the token moves
//   one cell per cycle around the ring.
// Note off, voice done, unused command: no search, straight to commit.
// One item at a time; the next input beat is taken while a result waits.
// Reset: all voices idle, search start and note counter zero, policy
//   oldest, voice count maximum; writing voice_count clears the voices,
//   search start and note counter.
module polyphonic_voice_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pva_pkg::CMD_W-1:0]     command,
    input  logic [pva_pkg::NOTE_W-1:0]    note,
    input  logic [pva_pkg::VEL_W-1:0]     velocity,
    input  logic [pva_pkg::VID_W-1:0]     voice_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pva_pkg::ASSIGN_W-1:0]  assigned_voice,
    output logic                          stole_voice,
    output logic                          start_valid,
    output logic [pva_pkg::NOTE_W-1:0]    out_note,
    output logic [pva_pkg::VEL_W-1:0]     out_velocity,
    output logic [pva_pkg::MASK_W-1:0]    released_mask,
    input  logic                          cfg_we,
    input  logic [pva_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pva_pkg::CFG_W-1:0]     cfg_data
);

    pva_pkg::token_t                  tok_out [pva_pkg::VOICE_SLOTS];
    pva_pkg::token_t                  tok_in  [pva_pkg::VOICE_SLOTS];
    pva_pkg::token_t                  scan_res;
    pva_pkg::token_t                  launch_tok;
    pva_pkg::bcast_t                  bc;
    logic                             launch;
    logic [pva_pkg::VOICE_W-1:0]      start_idx;
    logic [pva_pkg::CNT_W-1:0]        count;
    logic [pva_pkg::VOICE_W-1:0]      last_idx;
    logic [pva_pkg::VOICE_SLOTS-1:0]  active;
    logic [pva_pkg::VOICE_SLOTS-1:0]  rel_hit;
    logic [pva_pkg::VOICE_SLOTS-1:0]  live;

    assign last_idx = pva_pkg::VOICE_W'(count - pva_pkg::CNT_W'(1));

    pva_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .note           (note),
        .velocity       (velocity),
        .voice_id       (voice_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .assigned_voice (assigned_voice),
        .stole_voice    (stole_voice),
        .start_valid    (start_valid),
        .out_note       (out_note),
        .out_velocity   (out_velocity),
        .released_mask  (released_mask),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .scan_res       (scan_res),
        .rel_mask       (rel_hit),
        .bc             (bc),
        .launch         (launch),
        .launch_tok     (launch_tok),
        .start_idx      (start_idx),
        .count          (count)
    );

    for (genvar i = 0; i < pva_pkg::VOICE_SLOTS; i++)
    begin : g_cell
        pva_pkg::token_t prev_tok;

        if (i == 0)
        begin : g_wrap
            assign prev_tok = tok_out[last_idx];
        end
        else
        begin : g_link
            assign prev_tok = tok_out[i-1];
        end

        assign active[i] = (count > pva_pkg::CNT_W'(i));
        assign live[i]   = tok_out[i].valid;
        assign tok_in[i] = (launch && (start_idx == pva_pkg::VOICE_W'(i))) ?
                           launch_tok : prev_tok;

        pva_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .my_idx  (pva_pkg::VOICE_W'(i)),
            .active  (active[i]),
            .tok_in  (tok_in[i]),
            .bc      (bc),
            .tok_out (tok_out[i]),
            .rel_hit (rel_hit[i])
        );
    end

    // finished token, wherever it stopped
    always_comb
    begin
        scan_res = '0;
        for (int i = 0; i < pva_pkg::VOICE_SLOTS; i++)
        begin
            if (tok_out[i].valid && tok_out[i].done)
            begin
                scan_res = pva_pkg::token_t'(scan_res | tok_out[i]);
            end
        end
    end

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(live))
        else $error("more than one search token in the ring");

    a_no_token_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (live == '0))
        else $error("input beat taken while a search runs");

    a_note_on_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && start_valid) |-> (released_mask == '0))
        else $error("note on result carries a release mask");

endmodule
